/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of aclk, ignored while aresetn is low.
`define ASSERT_CLKRST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication checked on every rising edge of aclk, including during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/mrfr_pkg.sv */
// Package: constants, result type and CRC-16/MODBUS byte step for the frame receiver.
package mrfr_pkg;

    localparam logic [7:0]  OWN_ADDRESS_RESET = 8'h01;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_WRITE_REG    = 8'h06;
    localparam logic [7:0]  FUNC_WRITE_REG_EX = 8'h86;
    localparam logic [7:0]  ECHO_MARK_BYTE    = 8'h00;

    localparam int          POS_W             = 9;
    localparam logic [8:0]  POS_FUNCTION      = 9'd1;
    localparam logic [8:0]  POS_THIRD         = 9'd2;
    localparam logic [8:0]  POS_FIRST_DATA    = 9'd3;
    localparam logic [8:0]  POS_ECHO_END      = 9'd6;

    localparam logic        KIND_DATA         = 1'b0;
    localparam logic        KIND_STATUS       = 1'b1;

    localparam int          TDATA_W           = 80;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [7:0]  byte_count;
        logic [15:0] reg_address;
        logic [15:0] reg_value;
        logic        crc_ok;
        logic        address_match;
        logic        echo_form;
    } result_t;

    // Reflected CRC-16, one byte: eight shift-and-xor steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/modbus_rtu_frame_receiver.sv */
// Modbus RTU response frame receiver with CRC-16/MODBUS check (top level).
//
//  channel | dir | handshake             | payload
//  s_axis  | in  | s_axis_tvalid/tready  | tdata: rx_byte; tuser: frame_start
//  m_axis  | out | m_axis_tvalid/tready  | tdata: result fields; tuser: kind
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_data: own_address
//
//  One word accepted per cycle while m_axis is not stalled; a word passes through the input
//  register, then the parse/CRC step into the result register.
//  The CRC step is one byte of the reflected polynomial per word, unrolled over 8 bits.
//  aresetn is synchronous; all frame state is back to idle at the edge that samples it low.
//  A stall on m_axis fills the input register, then drops s_axis_tready.
`include "assert_macros.svh"

module modbus_rtu_frame_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    input  logic                          s_axis_tuser,  // [0] frame_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] data_byte, [15:8] data_index, [23:16] slave_address,
    // [31:24] function_code, [39:32] byte_count, [55:40] reg_address,
    // [71:56] reg_value, [72] crc_ok, [73] address_match, [74] echo_form,
    // [79:75] zero
    output logic [mrfr_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser,  // [0] kind
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_data       // own_address
);

    // configuration
    logic [7:0] own_address_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // frame state
    logic [mrfr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held_addr_reg, held_addr_next;
    logic [7:0]  held_func_reg, held_func_next;
    logic [7:0]  held_count_reg, held_count_next;
    logic        held_echo_reg, held_echo_next;
    logic [23:0] held_regs_reg, held_regs_next;
    logic [7:0]  held_crc_reg, held_crc_next;
    logic        active_reg, active_next;

    // result register
    logic                  m_valid_reg;
    mrfr_pkg::result_t     res_reg;
    mrfr_pkg::result_t     res_next;
    logic                  res_hit;

    logic                         consume;
    logic [mrfr_pkg::POS_W-1:0]   data_end;
    logic [mrfr_pkg::POS_W-1:0]   pos_data;

    assign consume       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;
    assign cfg_ready     = 1'b1;

    assign data_end = held_echo_reg ? mrfr_pkg::POS_ECHO_END
                                    : mrfr_pkg::POS_FIRST_DATA + {1'b0, held_count_reg};
    assign pos_data = pos_reg - mrfr_pkg::POS_FIRST_DATA;

    always_comb begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        held_addr_next  = held_addr_reg;
        held_func_next  = held_func_reg;
        held_count_next = held_count_reg;
        held_echo_next  = held_echo_reg;
        held_regs_next  = held_regs_reg;
        held_crc_next   = held_crc_reg;
        active_next     = active_reg;
        res_hit         = 1'b0;
        res_next        = '0;

        if (in_start_reg) begin
            // start flag always opens a fresh frame, dropping any partial one
            crc_next        = mrfr_pkg::crc16_byte(mrfr_pkg::CRC_INIT, in_byte_reg);
            held_addr_next  = in_byte_reg;
            held_func_next  = '0;
            held_count_next = '0;
            held_echo_next  = 1'b0;
            held_regs_next  = '0;
            held_crc_next   = '0;
            pos_next        = mrfr_pkg::POS_FUNCTION;
            active_next     = 1'b1;
        end else if (active_reg) begin
            if (pos_reg == mrfr_pkg::POS_FUNCTION) begin
                held_func_next = in_byte_reg;
                crc_next       = mrfr_pkg::crc16_byte(crc_reg, in_byte_reg);
                pos_next       = mrfr_pkg::POS_THIRD;
            end else if (pos_reg == mrfr_pkg::POS_THIRD) begin
                held_echo_next  = ((held_func_reg == mrfr_pkg::FUNC_WRITE_REG) ||
                                   (held_func_reg == mrfr_pkg::FUNC_WRITE_REG_EX)) &&
                                  (in_byte_reg == mrfr_pkg::ECHO_MARK_BYTE);
                held_count_next = held_echo_next ? 8'h00 : in_byte_reg;
                crc_next        = mrfr_pkg::crc16_byte(crc_reg, in_byte_reg);
                pos_next        = mrfr_pkg::POS_FIRST_DATA;
            end else if (pos_reg < data_end) begin
                crc_next = mrfr_pkg::crc16_byte(crc_reg, in_byte_reg);
                pos_next = pos_reg + 9'd1;
                if (held_echo_reg) begin
                    held_regs_next = {held_regs_reg[15:0], in_byte_reg};
                end else begin
                    res_hit             = 1'b1;
                    res_next.kind       = mrfr_pkg::KIND_DATA;
                    res_next.data_byte  = in_byte_reg;
                    res_next.data_index = pos_data[7:0];
                end
            end else if (pos_reg == data_end) begin
                held_crc_next = in_byte_reg;
                pos_next      = pos_reg + 9'd1;
            end else begin
                // second CRC byte closes the frame; CRC is sent low byte first
                active_next            = 1'b0;
                pos_next               = '0;
                res_hit                = 1'b1;
                res_next.kind          = mrfr_pkg::KIND_STATUS;
                res_next.slave_address = held_addr_reg;
                res_next.function_code = held_func_reg;
                res_next.byte_count    = held_count_reg;
                if (held_echo_reg) begin
                    res_next.reg_address = {8'h00, held_regs_reg[23:16]};
                    res_next.reg_value   = held_regs_reg[15:0];
                end
                res_next.crc_ok        = (held_crc_reg == crc_reg[7:0]) &&
                                         (in_byte_reg == crc_reg[15:8]);
                res_next.address_match = (held_addr_reg == own_address_reg);
                res_next.echo_form     = held_echo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= mrfr_pkg::OWN_ADDRESS_RESET;
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            pos_reg         <= '0;
            crc_reg         <= mrfr_pkg::CRC_INIT;
            held_addr_reg   <= '0;
            held_func_reg   <= '0;
            held_count_reg  <= '0;
            held_echo_reg   <= 1'b0;
            held_regs_reg   <= '0;
            held_crc_reg    <= '0;
            active_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                own_address_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                m_valid_reg    <= res_hit;
                pos_reg        <= pos_next;
                crc_reg        <= crc_next;
                held_addr_reg  <= held_addr_next;
                held_func_reg  <= held_func_next;
                held_count_reg <= held_count_next;
                held_echo_reg  <= held_echo_next;
                held_regs_reg  <= held_regs_next;
                held_crc_reg   <= held_crc_next;
                active_reg     <= active_next;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (consume && res_hit) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {5'b00000, res_reg.echo_form, res_reg.address_match, res_reg.crc_ok,
                            res_reg.reg_value, res_reg.reg_address, res_reg.byte_count,
                            res_reg.function_code, res_reg.slave_address,
                            res_reg.data_index, res_reg.data_byte};

    `ASSERT_CLKRST(a_idle_pos_zero, !active_reg |-> (pos_reg == '0), "idle with nonzero position")
    `ASSERT_CLKRST(a_status_ends_frame, (consume && res_hit && (res_next.kind == mrfr_pkg::KIND_STATUS)) |=> !active_reg, "frame still active after status word")
    `ASSERT_CLKRST(a_data_not_echo, (consume && res_hit && (res_next.kind == mrfr_pkg::KIND_DATA)) |-> (!held_echo_reg && active_reg), "data word from echo or idle frame")
    `ASSERT_CLK(a_reset_clears, !aresetn |=> (!m_valid_reg && !in_valid_reg && !active_reg), "reset left pipeline busy")

endmodule
